// File: rtl/esd_pkg.sv
// shared types, codes and character helpers for the escape sequence decoder
package esd_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_ESC   = 8'd27;
  localparam logic [7:0] CH_LF    = 8'h0a;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  out_kind;
    logic [15:0] out_count;
    logic        out_last;
  } result_t;

  // one queue entry holds all results caused by one input byte
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end else begin
      v = c - 8'h30;
    end
    return v[3:0];
  endfunction

  function automatic logic [7:0] escape_map(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h30:   r = 8'd0;
      8'h61:   r = 8'd7;
      8'h62:   r = 8'd8;
      8'h65:   r = CH_ESC;
      8'h66:   r = 8'd12;
      8'h6e:   r = CH_LF;
      8'h72:   r = 8'd13;
      8'h74:   r = 8'd9;
      8'h76:   r = 8'd11;
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] c);
    return (c == 16'hffff) ? c : c + 16'd1;
  endfunction

endpackage

// File: rtl/escape_sequence_decoder_core.sv
// top level of the backslash escape decoder
//
// input channel s_*: one string byte per beat in s_tdata; a zero byte ends
// the string. output channel m_*: one result per beat, m_tuser holds the
// kind (0 decoded byte, 1 string done, 2 bad hex escape), m_tdata holds the
// byte and the running count, m_tlast marks the last result of an input.
// an input byte gives zero, one or two results.
// the front decodes one byte per cycle while s_tready is high and writes
// its results as one entry into a short queue; the back emits one result
// per cycle while m_tready is high, from the queue head through an output
// register. throughput is one input byte per cycle as long as each gives
// at most one result; a byte with two results takes two output beats, and
// the queue absorbs these until it fills (QUEUE_DEPTH entries).
// when m_tready is low the output register holds its beat, the queue fills,
// and s_tready then drops until space frees up.
// synchronous reset returns to plain text mode with a zero count and clears
// the queue and the output valid.
module escape_sequence_decoder_core #(
  parameter int QUEUE_DEPTH = esd_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] out_count
  output logic [1:0]  m_tuser,   // [1:0] out_kind
  output logic        m_tlast
);

  logic             push;
  logic             pop;
  esd_pkg::entry_t  push_entry;
  esd_pkg::entry_t  head;
  esd_pkg::q_stat_t q_stat;

  esd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  esd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  esd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// File: rtl/esd_front.sv
// front end: accepts input bytes, tracks the escape mode and builds result entries
module esd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,   // [7:0] in_byte
  input  esd_pkg::q_stat_t q_stat,
  output logic            push,
  output esd_pkg::entry_t push_entry
);

  localparam logic [2:0] MODE_TEXT = 3'd0;
  localparam logic [2:0] MODE_ESC  = 3'd1;
  localparam logic [2:0] MODE_HEX0 = 3'd2;
  localparam logic [2:0] MODE_HEX1 = 3'd3;
  localparam logic [2:0] MODE_SKIP = 3'd4;

  logic [2:0]  mode, mode_next;
  logic [3:0]  nibble, nibble_next;
  logic [15:0] count, count_next;

  logic        accept;
  logic        n0, n1, end_str;
  logic [7:0]  byte0, byte1;
  logic [1:0]  kind0, kind1;
  logic [15:0] c0, c1;
  logic [7:0]  b;

  assign b        = s_tdata;
  assign s_tready = !q_stat.full;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    mode_next   = mode;
    nibble_next = nibble;
    n0 = 1'b0;
    n1 = 1'b0;
    end_str = 1'b0;
    byte0 = 8'd0;
    byte1 = 8'd0;
    kind0 = esd_pkg::KIND_BYTE;
    kind1 = esd_pkg::KIND_BYTE;
    case (mode)
      MODE_ESC: begin
        if (b == esd_pkg::CH_NUL) begin
          n0 = 1'b1;
          n1 = 1'b1;
          kind1 = esd_pkg::KIND_DONE;
          end_str = 1'b1;
        end else if (b == esd_pkg::CH_X) begin
          mode_next = MODE_HEX0;
        end else begin
          n0 = 1'b1;
          byte0 = esd_pkg::escape_map(b);
          mode_next = MODE_TEXT;
        end
      end
      MODE_HEX0: begin
        if (esd_pkg::is_hex(b)) begin
          nibble_next = esd_pkg::hex_val(b);
          mode_next = MODE_HEX1;
        end else begin
          n0 = 1'b1;
          kind0 = esd_pkg::KIND_ERR;
          if (b == esd_pkg::CH_NUL) begin
            end_str = 1'b1;
          end else begin
            mode_next = MODE_SKIP;
          end
        end
      end
      MODE_HEX1: begin
        n0 = 1'b1;
        nibble_next = 4'd0;
        mode_next = MODE_TEXT;
        if (esd_pkg::is_hex(b)) begin
          byte0 = {nibble, esd_pkg::hex_val(b)};
        end else begin
          // single digit escape, then the byte is plain text
          byte0 = {4'd0, nibble};
          if (b == esd_pkg::CH_NUL) begin
            n1 = 1'b1;
            kind1 = esd_pkg::KIND_DONE;
            end_str = 1'b1;
          end else if (b == esd_pkg::CH_BSLASH) begin
            mode_next = MODE_ESC;
          end else begin
            n1 = 1'b1;
            byte1 = b;
          end
        end
      end
      MODE_SKIP: begin
        if (b == esd_pkg::CH_NUL) begin
          end_str = 1'b1;
        end
      end
      default: begin
        if (b == esd_pkg::CH_NUL) begin
          n0 = 1'b1;
          kind0 = esd_pkg::KIND_DONE;
          end_str = 1'b1;
        end else if (b == esd_pkg::CH_BSLASH) begin
          mode_next = MODE_ESC;
        end else begin
          n0 = 1'b1;
          byte0 = b;
          mode_next = MODE_TEXT;
        end
      end
    endcase

    c0 = (n0 && kind0 == esd_pkg::KIND_BYTE) ? esd_pkg::sat_inc(count) : count;
    c1 = (n1 && kind1 == esd_pkg::KIND_BYTE) ? esd_pkg::sat_inc(c0) : c0;

    if (end_str) begin
      mode_next   = MODE_TEXT;
      nibble_next = 4'd0;
      count_next  = 16'd0;
    end else begin
      count_next  = c1;
    end
  end

  always_comb begin
    push_entry.two          = n1;
    push_entry.r0.out_byte  = byte0;
    push_entry.r0.out_kind  = kind0;
    push_entry.r0.out_count = c0;
    push_entry.r0.out_last  = !n1;
    push_entry.r1.out_byte  = byte1;
    push_entry.r1.out_kind  = kind1;
    push_entry.r1.out_count = c1;
    push_entry.r1.out_last  = 1'b1;
  end

  assign push = accept && n0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_TEXT;
      nibble <= 4'd0;
      count  <= 16'd0;
    end else if (accept) begin
      mode   <= mode_next;
      nibble <= nibble_next;
      count  <= count_next;
    end
  end

  a_term_resets_mode: assert property (@(posedge clk) disable iff (rst)
    accept && b == esd_pkg::CH_NUL |=> mode == MODE_TEXT && count == 16'd0)
    else $error("terminator did not end the string");

  a_second_needs_first: assert property (@(posedge clk) disable iff (rst)
    n1 |-> n0)
    else $error("second result without a first");

endmodule

// File: rtl/esd_queue.sv
// short register queue of result entries between front and back
module esd_queue #(
  parameter int DEPTH = esd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  esd_pkg::entry_t  push_entry,
  input  logic             pop,
  output esd_pkg::entry_t  head,
  output esd_pkg::q_stat_t q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  esd_pkg::entry_t slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] fill;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign q_stat.full  = (fill == CW'(DEPTH));
  assign q_stat.empty = (fill == '0);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !push)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_stat.empty |-> !pop)
    else $error("pop from empty queue");

endmodule

// File: rtl/esd_back.sv
// back end: unpacks queue entries into single result beats on the output register
module esd_back (
  input  logic             clk,
  input  logic             rst,
  input  esd_pkg::entry_t  head,
  input  esd_pkg::q_stat_t q_stat,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [23:0]      m_tdata,   // [7:0] out_byte, [23:8] out_count
  output logic [1:0]       m_tuser,   // [1:0] out_kind
  output logic             m_tlast
);

  logic            sub;
  logic            load;
  esd_pkg::result_t sel;
  esd_pkg::result_t out_res;

  assign load = !q_stat.empty && (!m_tvalid || m_tready);
  assign sel  = sub ? head.r1 : head.r0;
  // the entry leaves once its last result is loaded
  assign pop  = load && (sub || !head.two);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      sub      <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        sub      <= !pop;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= sel;
    end
  end

  assign m_tdata = {out_res.out_count, out_res.out_byte};
  assign m_tuser = out_res.out_kind;
  assign m_tlast = out_res.out_last;

  a_sub_has_entry: assert property (@(posedge clk) disable iff (rst)
    sub |-> !q_stat.empty)
    else $error("second result pending with empty queue");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == esd_pkg::KIND_DONE |-> m_tlast)
    else $error("done result not marked last");

endmodule
